### design/elf_build_id_note_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the build-id note parser
// Concurrent checks that are compiled away for synthesis.
// ----------------------------------------------------------------------------
`ifndef ELF_BUILD_ID_NOTE_PARSER_MACROS_SVH
`define ELF_BUILD_ID_NOTE_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define BIDP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bidp: same-cycle check failed");
`define BIDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bidp: next-cycle check failed");
`else
`define BIDP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BIDP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### design/bidp_pkg.sv
// ----------------------------------------------------------------------------
// Build-id note parser package
// Shared types, codes and character helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bidp_pkg;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_NAME   = 2'd1,
      PH_DESC   = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_READ,
      ST_LOAD
   } ctrl_state_type;

   localparam logic [1:0]  STATUS_ID        = 2'd0;
   localparam logic [1:0]  STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0]  STATUS_MALFORMED = 2'd2;

   localparam logic [31:0] NOTE_BUILD_ID = 32'd3;
   localparam logic [31:0] NAME_BYTES    = 32'd4;
   localparam logic [31:0] MIN_ID_BYTES  = 32'd4;
   localparam logic [3:0]  HEADER_LAST   = 4'd11;

   localparam logic [6:0]  ASCII_ZERO   = 7'h30;
   localparam logic [6:0]  ASCII_A_BASE = 7'h57;
   localparam logic [3:0]  DEC_DIGITS   = 4'd10;

   typedef struct packed {
      logic byte_accept;
      logic rd_issue;
      logic id_load;
      logic emit_done;
   } dp_cmd_type;

   typedef struct packed {
      logic take_id;
      logic out_free;
      logic emit_last;
   } dp_status_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] c;
      if (nib < DEC_DIGITS) begin
         c = ASCII_ZERO + {3'b000, nib};
      end else begin
         c = ASCII_A_BASE + {3'b000, nib};
      end
      return c;
   endfunction

   function automatic logic [7:0] gnu_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h47;
         2'd1:    c = 8'h4e;
         2'd2:    c = 8'h55;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### design/bidp_datapath.sv
// ----------------------------------------------------------------------------
// Build-id note parser datapath
// Note header capture, field countdown, name match, descriptor buffer,
// hex conversion and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "elf_build_id_note_parser_macros.svh"

module bidp_datapath #(
   parameter int MAX_ID_BYTES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_segment_end,
   input  bidp_pkg::dp_cmd_type    dp_cmd,
   output bidp_pkg::dp_status_type dp_status,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [6:0]             rsp_hex_high,
   output logic [6:0]             rsp_hex_low,
   output logic [1:0]             rsp_status,
   output logic                   rsp_run_end
);
   import bidp_pkg::*;

   localparam int AW = $clog2(MAX_ID_BYTES);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] POS_MAX  = CW'(MAX_ID_BYTES);
   localparam logic [CW-1:0] POS_NAME = CW'(NAME_BYTES);
   localparam logic [31:0]   MAX_LEN  = 32'(MAX_ID_BYTES);

   phase_type        phase_ff, phase_in;
   logic [3:0]       hcount_ff, hcount_in;
   logic [31:0]      name_len_ff, name_len_in;
   logic [31:0]      desc_len_ff, desc_len_in;
   logic [31:0]      kind_ff, kind_in;
   logic [32:0]      remain_ff, remain_in;
   logic [CW-1:0]    pos_ff, pos_in;
   logic             match_ff, match_in;
   logic             found_ff, found_in;
   logic             end_pend_ff, end_pend_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [7:0]       rd_data_ff;
   logic [7:0]       id_mem [MAX_ID_BYTES];

   logic             rsp_valid_ff;
   logic [6:0]       rsp_hex_high_ff;
   logic [6:0]       rsp_hex_low_ff;
   logic [1:0]       rsp_status_ff;
   logic             rsp_run_end_ff;

   logic [32:0]      pad_name;
   logic [32:0]      pad_desc;
   logic [32:0]      remain_dec;
   logic             field_last;
   logic             is_id;
   logic             take_id;
   logic [CW-1:0]    pos_inc;
   logic             out_free;
   logic             emit_last;
   logic             stat_load;
   logic [1:0]       stat_code;

   assign pad_name   = ({1'b0, name_len_ff} + 33'd3) & ~33'd3;
   assign pad_desc   = ({1'b0, desc_len_ff} + 33'd3) & ~33'd3;
   assign remain_dec = remain_ff - 33'd1;
   assign field_last = (remain_dec == 33'd0);
   assign is_id      = (name_len_ff == NAME_BYTES) && match_ff &&
                       (kind_ff == NOTE_BUILD_ID) &&
                       (desc_len_ff >= MIN_ID_BYTES) && (desc_len_ff <= MAX_LEN);
   assign take_id    = (phase_ff == PH_DESC) && field_last && is_id;
   assign pos_inc    = (pos_ff == POS_MAX) ? pos_ff : pos_ff + CW'(1);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign emit_last  = (({1'b0, idx_ff} + CW'(1)) == desc_len_ff[CW-1:0]);

   assign dp_status.take_id   = take_id;
   assign dp_status.out_free  = out_free;
   assign dp_status.emit_last = emit_last;

   always_comb begin
      phase_in    = phase_ff;
      hcount_in   = hcount_ff;
      name_len_in = name_len_ff;
      desc_len_in = desc_len_ff;
      kind_in     = kind_ff;
      remain_in   = remain_ff;
      pos_in      = pos_ff;
      match_in    = match_ff;
      found_in    = found_ff;
      end_pend_in = end_pend_ff;
      stat_load   = 1'b0;
      stat_code   = STATUS_NOT_FOUND;
      if (dp_cmd.byte_accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (hcount_ff == 4'd0) begin
                  name_len_in = 32'd0;
                  desc_len_in = 32'd0;
                  kind_in     = 32'd0;
                  match_in    = 1'b1;
               end
               case (hcount_ff[3:2])
                  2'd0:    name_len_in[8*hcount_ff[1:0] +: 8] = req_data_byte;
                  2'd1:    desc_len_in[8*hcount_ff[1:0] +: 8] = req_data_byte;
                  default: kind_in[8*hcount_ff[1:0] +: 8]     = req_data_byte;
               endcase
               if (hcount_ff == HEADER_LAST) begin
                  hcount_in = 4'd0;
                  pos_in    = '0;
                  if (pad_name != 33'd0) begin
                     phase_in  = PH_NAME;
                     remain_in = pad_name;
                  end else begin
                     remain_in = pad_desc;
                     phase_in  = (pad_desc != 33'd0) ? PH_DESC : PH_HEADER;
                  end
               end else begin
                  hcount_in = hcount_ff + 4'd1;
               end
            end
            PH_NAME: begin
               if (pos_ff < POS_NAME && req_data_byte != gnu_char(pos_ff[1:0])) begin
                  match_in = 1'b0;
               end
               pos_in    = pos_inc;
               remain_in = remain_dec;
               if (field_last) begin
                  pos_in    = '0;
                  remain_in = pad_desc;
                  phase_in  = (pad_desc != 33'd0) ? PH_DESC : PH_HEADER;
               end
            end
            PH_DESC: begin
               pos_in    = pos_inc;
               remain_in = remain_dec;
               if (field_last) begin
                  if (is_id) begin
                     found_in = 1'b1;
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_HEADER;
                  end
               end
            end
            default: begin
            end
         endcase
         stat_load = req_segment_end && !found_in;
         stat_code = (phase_in == PH_HEADER) ? STATUS_NOT_FOUND : STATUS_MALFORMED;
         if (req_segment_end && take_id) begin
            end_pend_in = 1'b1;
         end
      end
      if ((dp_cmd.byte_accept && req_segment_end && !take_id) ||
          (dp_cmd.emit_done && end_pend_ff)) begin
         phase_in    = PH_HEADER;
         hcount_in   = 4'd0;
         name_len_in = 32'd0;
         desc_len_in = 32'd0;
         kind_in     = 32'd0;
         remain_in   = 33'd0;
         pos_in      = '0;
         match_in    = 1'b1;
         found_in    = 1'b0;
         end_pend_in = 1'b0;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (dp_cmd.byte_accept && take_id) begin
         idx_in = '0;
      end else if (dp_cmd.id_load) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hcount_ff   <= 4'd0;
         name_len_ff <= 32'd0;
         desc_len_ff <= 32'd0;
         kind_ff     <= 32'd0;
         remain_ff   <= 33'd0;
         pos_ff      <= '0;
         match_ff    <= 1'b1;
         found_ff    <= 1'b0;
         end_pend_ff <= 1'b0;
         idx_ff      <= '0;
      end else begin
         phase_ff    <= phase_in;
         hcount_ff   <= hcount_in;
         name_len_ff <= name_len_in;
         desc_len_ff <= desc_len_in;
         kind_ff     <= kind_in;
         remain_ff   <= remain_in;
         pos_ff      <= pos_in;
         match_ff    <= match_in;
         found_ff    <= found_in;
         end_pend_ff <= end_pend_in;
         idx_ff      <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.byte_accept && phase_ff == PH_DESC && pos_ff < POS_MAX) begin
         id_mem[pos_ff[AW-1:0]] <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.rd_issue) begin
         rd_data_ff <= id_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stat_load || dp_cmd.id_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stat_load) begin
         rsp_hex_high_ff <= ASCII_ZERO;
         rsp_hex_low_ff  <= ASCII_ZERO;
         rsp_status_ff   <= stat_code;
         rsp_run_end_ff  <= 1'b1;
      end else if (dp_cmd.id_load) begin
         rsp_hex_high_ff <= hex_char(rd_data_ff[7:4]);
         rsp_hex_low_ff  <= hex_char(rd_data_ff[3:0]);
         rsp_status_ff   <= STATUS_ID;
         rsp_run_end_ff  <= emit_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hex_high = rsp_hex_high_ff;
   assign rsp_hex_low  = rsp_hex_low_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_run_end  = rsp_run_end_ff;

   `BIDP_ASSERT_IMPLY(a_stat_slot_free, clock, reset, stat_load, out_free)
   `BIDP_ASSERT_IMPLY(a_emit_in_done, clock, reset, dp_cmd.id_load, phase_ff == PH_DONE && found_ff)
   `BIDP_ASSERT_IMPLY(a_status_ends_run, clock, reset, rsp_valid_ff && rsp_status_ff != STATUS_ID, rsp_run_end_ff)

endmodule

### design/bidp_ctrl.sv
// ----------------------------------------------------------------------------
// Build-id note parser controller
// Sequences byte intake and the buffer read-out of a found build id.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "elf_build_id_note_parser_macros.svh"

module bidp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_segment_end,
   output logic                    req_ready,
   input  bidp_pkg::dp_status_type dp_status,
   output bidp_pkg::dp_cmd_type    dp_cmd
);
   import bidp_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      dp_cmd    = '0;
      unique case (state_ff)
         ST_RUN: begin
            // hold a segment-end word until the result slot is free
            req_ready          = dp_status.out_free || !req_segment_end;
            dp_cmd.byte_accept = req_valid && req_ready;
            if (dp_cmd.byte_accept && dp_status.take_id) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            dp_cmd.rd_issue = 1'b1;
            state_in        = ST_LOAD;
         end
         ST_LOAD: begin
            if (dp_status.out_free) begin
               dp_cmd.id_load = 1'b1;
               if (dp_status.emit_last) begin
                  dp_cmd.emit_done = 1'b1;
                  state_in         = ST_RUN;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   `BIDP_ASSERT_IMPLY(a_ready_only_run, clock, reset, req_ready, state_ff == ST_RUN)
   `BIDP_ASSERT_NEXT(a_read_then_load, clock, reset, state_ff == ST_READ, state_ff == ST_LOAD)
   `BIDP_ASSERT_IMPLY(a_load_slot_free, clock, reset, dp_cmd.id_load, dp_status.out_free)

endmodule

### design/elf_build_id_note_parser.sv
// ----------------------------------------------------------------------------
// ELF build-id note parser
// Walks one ELF note segment, one byte per accepted word, and returns the
// GNU build id of the first note named "GNU" with type 3 and a descriptor of
// 4 to MAX_ID_BYTES bytes, one word per id byte as two lower-case hex
// characters, the last word marked with run_end. A segment that ends without
// a find returns one status word: not found on a note boundary or inside a
// header, malformed inside a name or descriptor. Note bytes are taken at one
// per cycle. Once the last padded descriptor byte of a build id arrives, the
// input is held while each id byte is read from the descriptor buffer and
// then loaded into the result register, and also while a loaded id word
// waits on the result side. A segment-end byte is held only while the
// result register is still full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elf_build_id_note_parser #(
   parameter int MAX_ID_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_segment_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_hex_high,
   output logic [6:0] rsp_hex_low,
   output logic [1:0] rsp_status,
   output logic       rsp_run_end
);
   import bidp_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   bidp_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_segment_end (req_segment_end),
      .req_ready       (req_ready),
      .dp_status       (dp_status),
      .dp_cmd          (dp_cmd)
   );

   bidp_datapath #(
      .MAX_ID_BYTES (MAX_ID_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_data_byte),
      .req_segment_end (req_segment_end),
      .dp_cmd          (dp_cmd),
      .dp_status       (dp_status),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_hex_high    (rsp_hex_high),
      .rsp_hex_low     (rsp_hex_low),
      .rsp_status      (rsp_status),
      .rsp_run_end     (rsp_run_end)
   );

endmodule

### verif/elf_build_id_note_checker.sv
// ----------------------------------------------------------------------------
// Build-id note parser checker
// Watches the byte and result channels of the note parser, walks the note
// segment alongside the block, queues the words that each accepted byte
// should cause and compares every returned word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elf_build_id_note_checker #(
   parameter int MAX_ID_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_segment_end,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [6:0] rsp_hex_high,
   input  logic [6:0] rsp_hex_low,
   input  logic [1:0] rsp_status,
   input  logic       rsp_run_end,
   output int         fail_count,
   output int         pending_words
);
   import bidp_pkg::*;

   localparam logic [127:0] HEX_TEXT = "0123456789abcdef";
   localparam logic [31:0]  GNU_TAG  = 32'h00554e47;

   typedef struct packed {
      logic [6:0] hex_high;
      logic [6:0] hex_low;
      logic [1:0] status;
      logic       run_end;
   } id_word_type;

   id_word_type expected_words[$];
   id_word_type got_word;
   id_word_type want_word;

   phase_type   walk_phase;
   logic [3:0]  hdr_idx;
   logic [31:0] name_size;
   logic [31:0] desc_size;
   logic [31:0] note_kind;
   logic [32:0] bytes_left;
   logic        name_ok;
   logic        id_found;
   logic [7:0]  id_bytes [MAX_ID_BYTES];

   function automatic logic [6:0] hex_digit(input logic [3:0] nib);
      return HEX_TEXT[(15 - nib) * 8 +: 7];
   endfunction

   function automatic logic [32:0] pad4(input logic [31:0] v);
      return ({1'b0, v} + 33'd3) & ~33'd3;
   endfunction

   function void clear_walk();
      walk_phase = PH_HEADER;
      hdr_idx    = '0;
      name_size  = '0;
      desc_size  = '0;
      note_kind  = '0;
      bytes_left = '0;
      name_ok    = 1'b1;
      id_found   = 1'b0;
   endfunction

   function void open_descriptor();
      bytes_left = pad4(desc_size);
      walk_phase = (bytes_left != '0) ? PH_DESC : PH_HEADER;
   endfunction

   function void walk_note_byte(input logic [7:0] b, input logic last);
      logic [32:0] pos;
      id_word_type w;
      case (walk_phase)
         PH_HEADER: begin
            if (hdr_idx == 4'd0) begin
               name_size = '0;
               desc_size = '0;
               note_kind = '0;
               name_ok   = 1'b1;
            end
            if (hdr_idx < 4'd4) begin
               name_size[hdr_idx[1:0] * 8 +: 8] = b;
            end else if (hdr_idx < 4'd8) begin
               desc_size[hdr_idx[1:0] * 8 +: 8] = b;
            end else begin
               note_kind[hdr_idx[1:0] * 8 +: 8] = b;
            end
            if (hdr_idx == HEADER_LAST) begin
               hdr_idx = '0;
               bytes_left = pad4(name_size);
               if (bytes_left != '0) begin
                  walk_phase = PH_NAME;
               end else begin
                  open_descriptor();
               end
            end else begin
               hdr_idx = hdr_idx + 4'd1;
            end
         end
         PH_NAME: begin
            pos = pad4(name_size) - bytes_left;
            if (pos < 33'd4 && b != GNU_TAG[pos[1:0] * 8 +: 8]) begin
               name_ok = 1'b0;
            end
            bytes_left = bytes_left - 33'd1;
            if (bytes_left == '0) begin
               open_descriptor();
            end
         end
         PH_DESC: begin
            pos = pad4(desc_size) - bytes_left;
            if (pos < MAX_ID_BYTES) begin
               id_bytes[int'(pos)] = b;
            end
            bytes_left = bytes_left - 33'd1;
            if (bytes_left == '0) begin
               if (name_size == NAME_BYTES && name_ok && note_kind == NOTE_BUILD_ID &&
                   desc_size >= MIN_ID_BYTES && desc_size <= MAX_ID_BYTES) begin
                  for (int i = 0; i < desc_size; i++) begin
                     w.hex_high = hex_digit(id_bytes[i][7:4]);
                     w.hex_low  = hex_digit(id_bytes[i][3:0]);
                     w.status   = STATUS_ID;
                     w.run_end  = (i + 1 == desc_size);
                     expected_words = {expected_words, w};
                  end
                  id_found   = 1'b1;
                  walk_phase = PH_DONE;
               end else begin
                  walk_phase = PH_HEADER;
               end
            end
         end
         default: begin
         end
      endcase
      if (last) begin
         if (!id_found) begin
            w.hex_high = ASCII_ZERO;
            w.hex_low  = ASCII_ZERO;
            w.status   = (walk_phase == PH_HEADER) ? STATUS_NOT_FOUND : STATUS_MALFORMED;
            w.run_end  = 1'b1;
            expected_words = {expected_words, w};
         end
         clear_walk();
      end
   endfunction

   function void check_field(input string field, input logic [6:0] want, input logic [6:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_walk();
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (req_valid && req_ready) begin
            walk_note_byte(req_data_byte, req_segment_end);
         end
         if (rsp_valid && rsp_ready) begin
            got_word = {rsp_hex_high, rsp_hex_low, rsp_status, rsp_run_end};
            if (expected_words.size() == 0) begin
               $error("unexpected word: hex_high %0d hex_low %0d status %0d run_end %0d",
                      rsp_hex_high, rsp_hex_low, rsp_status, rsp_run_end);
               fail_count++;
            end else begin
               want_word = expected_words.pop_front();
               check_field("hex_high", want_word.hex_high, got_word.hex_high);
               check_field("hex_low", want_word.hex_low, got_word.hex_low);
               check_field("status", {5'd0, want_word.status}, {5'd0, got_word.status});
               check_field("run_end", {6'd0, want_word.run_end}, {6'd0, got_word.run_end});
            end
         end
      end
      pending_words <= expected_words.size();
   end

endmodule

### verif/elf_build_id_note_parser_tb.sv
// ----------------------------------------------------------------------------
// Build-id note parser testbench
// Feeds note segments byte by byte: directed segments for the id size limits,
// name and type mismatches, every place a segment can end and huge sizes,
// then random segments, mostly well-formed notes with random content, some
// cut short and some pure noise. Both sides stall at random; the checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elf_build_id_note_parser_tb;
   import bidp_pkg::*;

   localparam int          WATCHDOG_LIMIT = 1000;
   localparam int          ITEM_COUNT     = 420;
   localparam int          TAIL_CYCLES    = 200;
   localparam logic [31:0] GNU_TAG        = 32'h00554e47;

   typedef enum int {
      NAME_RANDOM,
      NAME_GNU,
      NAME_CORRUPT
   } name_mode_type;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte   = 8'h00;
   logic       req_segment_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready       = 1'b0;
   logic [6:0] rsp_hex_high;
   logic [6:0] rsp_hex_low;
   logic [1:0] rsp_status;
   logic       rsp_run_end;

   logic       calm = 1'b0;
   int         ready_hold = 0;
   int         ready_draw;
   int         idle_cycles = 0;
   int         sent_bytes = 0;
   int         fail_count;
   int         pending_words;
   logic [7:0] seg_q[$];

   elf_build_id_note_parser #(
      .MAX_ID_BYTES(64)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_segment_end(req_segment_end),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hex_high(rsp_hex_high),
      .rsp_hex_low(rsp_hex_low),
      .rsp_status(rsp_status),
      .rsp_run_end(rsp_run_end)
   );

   elf_build_id_note_checker #(
      .MAX_ID_BYTES(64)
   ) words (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_segment_end(req_segment_end),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hex_high(rsp_hex_high),
      .rsp_hex_low(rsp_hex_low),
      .rsp_status(rsp_status),
      .rsp_run_end(rsp_run_end),
      .fail_count(fail_count),
      .pending_words(pending_words)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_hold <= 0;
      end else if (rsp_valid && rsp_ready) begin
         ready_draw = calm ? 0 : $urandom_range(0, 13);
         ready_hold <= ready_draw;
         rsp_ready  <= (ready_draw == 0);
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready  <= (ready_hold == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic put_byte(input logic [7:0] b);
      seg_q = {seg_q, b};
   endtask

   task automatic put_word(input logic [31:0] v);
      for (int i = 0; i < 4; i++) begin
         put_byte(v[i * 8 +: 8]);
      end
   endtask

   task automatic put_note(input int name_len, input int desc_len, input logic [31:0] note_type,
                           input name_mode_type name_mode, input bit ladder);
      int         bad_pos;
      logic [7:0] b;
      bad_pos = $urandom_range(0, 3);
      put_word(name_len);
      put_word(desc_len);
      put_word(note_type);
      for (int i = 0; i < ((name_len + 3) & ~3); i++) begin
         b = 8'($urandom_range(0, 255));
         if (name_mode != NAME_RANDOM && i < 4) begin
            b = GNU_TAG[i * 8 +: 8];
         end
         if (name_mode == NAME_CORRUPT && i == bad_pos) begin
            b = b ^ (8'h01 << $urandom_range(0, 7));
         end
         put_byte(b);
      end
      // ladder: 00, 11, .. ff up front puts every digit in both nibbles
      for (int i = 0; i < ((desc_len + 3) & ~3); i++) begin
         put_byte((ladder && i < 16) ? 8'(i * 17) : 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_segment_end <= last;
      do @(posedge clock); while (!req_ready);
      sent_bytes++;
   endtask

   // send the first count bytes, the last one flagged, and drop the rest
   task automatic send_segment(input int count);
      for (int i = 0; i < count; i++) begin
         send_byte(seg_q[i], i == count - 1);
      end
      seg_q.delete();
   endtask

   initial begin
      int cut;
      int kind;
      int desc_len;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      put_note(4, 4, NOTE_BUILD_ID, NAME_GNU, 1'b0);
      send_segment(seg_q.size());
      put_note(4, 64, NOTE_BUILD_ID, NAME_GNU, 1'b1);
      repeat (6) put_byte(8'($urandom_range(0, 255)));
      send_segment(seg_q.size());
      put_note(4, 65, NOTE_BUILD_ID, NAME_GNU, 1'b0);
      put_note(4, 3, NOTE_BUILD_ID, NAME_GNU, 1'b0);
      send_segment(seg_q.size());
      put_note(4, 8, NOTE_BUILD_ID, NAME_CORRUPT, 1'b0);
      put_note(4, 8, 32'd2, NAME_GNU, 1'b0);
      put_note(5, 8, NOTE_BUILD_ID, NAME_GNU, 1'b0);
      put_note(0, 0, 32'd0, NAME_RANDOM, 1'b0);
      send_segment(seg_q.size());
      put_byte(8'hff);
      send_segment(1);
      put_note(0, 0, NOTE_BUILD_ID, NAME_RANDOM, 1'b0);
      send_segment(12);
      put_note(4, 4, NOTE_BUILD_ID, NAME_GNU, 1'b0);
      send_segment(12);
      put_note(4, 4, NOTE_BUILD_ID, NAME_GNU, 1'b0);
      send_segment(14);
      put_note(4, 8, NOTE_BUILD_ID, NAME_GNU, 1'b0);
      send_segment(16);
      put_note(4, 21, NOTE_BUILD_ID, NAME_GNU, 1'b0);
      send_segment(30);
      put_word(32'hffffffff);
      put_word(32'd4);
      put_word(NOTE_BUILD_ID);
      repeat (5) put_byte(8'($urandom_range(0, 255)));
      send_segment(seg_q.size());
      put_word(32'd0);
      put_word(32'hfffffffe);
      put_word(NOTE_BUILD_ID);
      repeat (7) put_byte(8'($urandom_range(0, 255)));
      send_segment(seg_q.size());

      while (sent_bytes < ITEM_COUNT) begin
         calm = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 19);
         if (kind < 3) begin
            repeat ($urandom_range(1, 30)) put_byte(8'($urandom_range(0, 255)));
            cut = seg_q.size();
         end else begin
            repeat ($urandom_range(0, 2)) begin
               put_note($urandom_range(0, 8), $urandom_range(0, 12), $urandom_range(0, 4),
                        name_mode_type'($urandom_range(0, 2)), 1'b0);
            end
            desc_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                   : $urandom_range(4, 16);
            if ($urandom_range(0, 9) == 0) begin
               desc_len = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(65, 70);
            end
            put_note(($urandom_range(0, 9) == 0) ? $urandom_range(3, 8) : 4, desc_len,
                     ($urandom_range(0, 7) == 0) ? $urandom : NOTE_BUILD_ID,
                     ($urandom_range(0, 7) == 0) ? NAME_CORRUPT : NAME_GNU, 1'b0);
            cut = seg_q.size();
            if (kind >= 15) begin
               cut = $urandom_range(1, cut);
            end else begin
               repeat ($urandom_range(0, 5)) put_byte(8'($urandom_range(0, 255)));
            end
         end
         send_segment((kind < 15) ? seg_q.size() : cut);
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending_words != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_words == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
+incdir+design
design/bidp_pkg.sv
design/bidp_datapath.sv
design/bidp_ctrl.sv
design/elf_build_id_note_parser.sv
verif/elf_build_id_note_checker.sv
verif/elf_build_id_note_parser_tb.sv
